// ===== hdl/pls_pkg.sv =====
// shared types and constants for the positional list store
`default_nettype none

package pls_pkg;

	// list geometry
	localparam int DEPTH       = 64;
	localparam int MAX_RESULTS = 64;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int POS_W       = 7;
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int DISP_N      = (DEPTH < MAX_RESULTS) ? DEPTH : MAX_RESULTS;

	// request codes
	typedef enum logic [2:0] {
		REQ_CLEAR   = 3'd0,
		REQ_APPEND  = 3'd1,
		REQ_MODIFY  = 3'd2,
		REQ_DISPLAY = 3'd3,
		REQ_INSERT  = 3'd4,
		REQ_DELETE  = 3'd5
	} req_code_t;

	// status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]        req_type;
		logic [POS_W-1:0]  position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] element;
		logic [POS_W-1:0]   element_index;
		logic [POS_W-1:0]   length;
		logic               last;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hdl/positional_list_store.sv =====
// positional list store: list memory, element count and shift/display sequencer
//
//  channel | signals                      | moves
//  --------+------------------------------+-----------------------------------
//  req     | req_valid, req_ready, req    | one request: code, position, word
//  rsp     | rsp_valid, rsp_ready, rsp    | results; last marks the final one
//
// clear, append, modify and rejected requests go straight to the result state.
// insert and delete move each shifted word with a read and then a write, the
// sequencer stepping through the list one element at a time.
// display reads each emitted element and then loads it as a result.
// reset clears the count and the sequencer; list memory is not cleared.
// req_ready is high only while idle; a stalled result holds the sequencer.
`default_nettype none

module positional_list_store
	import pls_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	// one-hot sequencer states
	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_RESP    = 9'b000000010,
		S_INS_RD  = 9'b000000100,
		S_INS_WR  = 9'b000001000,
		S_INS_VAL = 9'b000010000,
		S_DEL_RD  = 9'b000100000,
		S_DEL_WR  = 9'b001000000,
		S_DISP_RD = 9'b010000000,
		S_DISP_LD = 9'b100000000
	} state_t;

	state_t               state_q, state_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [ADDR_W-1:0]    idx_q, idx_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic signed [31:0]   val_q, val_d;
	status_t              status_q, status_d;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	logic                 rsp_load;
	rsp_t                 rsp_d;

	// list memory
	logic [31:0]          mem [DEPTH];
	logic [31:0]          rdata_q;
	logic                 we, re;
	logic [ADDR_W-1:0]    waddr, raddr;
	logic [31:0]          wdata;

	// widened views for compares
	logic [CMP_W-1:0]     cnt_x, req_pos_x, pos_x, idx_x, idx_inc_x;
	logic                 slot_free, req_fire, req_pos_ok, full, disp_last;
	logic [CNT_W-1:0]     disp_n;

	assign cnt_x     = CMP_W'(count_q);
	assign req_pos_x = CMP_W'(req.position);
	assign pos_x     = CMP_W'(pos_q);
	assign idx_x     = CMP_W'(idx_q);
	assign idx_inc_x = idx_x + CMP_W'(1);

	assign req_ready  = (state_q == S_IDLE);
	assign req_fire   = req_valid && req_ready;
	assign slot_free  = !rsp_valid_q || rsp_ready;
	assign req_pos_ok = (req_pos_x != '0) && (req_pos_x <= cnt_x);
	assign full       = (count_q == CNT_W'(DEPTH));
	assign disp_n     = (count_q < CNT_W'(DISP_N)) ? count_q : CNT_W'(DISP_N);
	assign disp_last  = (CNT_W'(idx_q) + CNT_W'(1)) == disp_n;

	// sequencer and memory port control
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		pos_d    = pos_q;
		val_d    = val_q;
		status_d = status_q;
		we       = 1'b0;
		re       = 1'b0;
		waddr    = idx_q;
		raddr    = idx_q;
		wdata    = val_q;
		rsp_load = 1'b0;
		rsp_d    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					pos_d    = req.position;
					val_d    = req.value;
					status_d = ST_OK;
					state_d  = S_RESP;
					unique case (req.req_type)
						REQ_CLEAR: begin
							count_d = '0;
						end
						REQ_APPEND: begin
							if (full) begin
								status_d = ST_FULL;
							end else begin
								we      = 1'b1;
								waddr   = ADDR_W'(count_q);
								wdata   = req.value;
								count_d = count_q + CNT_W'(1);
							end
						end
						REQ_MODIFY: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else if (!req_pos_ok) begin
								status_d = ST_BADPOS;
							end else begin
								we    = 1'b1;
								waddr = ADDR_W'(req_pos_x - CMP_W'(1));
								wdata = req.value;
							end
						end
						REQ_DISPLAY: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = S_DISP_RD;
							end
						end
						REQ_INSERT: begin
							if (!req_pos_ok) begin
								status_d = ST_BADPOS;
							end else if (full) begin
								status_d = ST_FULL;
							end else begin
								idx_d   = ADDR_W'(count_q);
								state_d = S_INS_RD;
							end
						end
						REQ_DELETE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else if (!req_pos_ok) begin
								status_d = ST_BADPOS;
							end else begin
								count_d = count_q - CNT_W'(1);
								idx_d   = ADDR_W'(req_pos_x - CMP_W'(1));
								state_d = S_DEL_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			// move the word below idx up by one
			S_INS_RD: begin
				re      = 1'b1;
				raddr   = idx_q - ADDR_W'(1);
				state_d = S_INS_WR;
			end
			S_INS_WR: begin
				we    = 1'b1;
				wdata = rdata_q;
				if (idx_x == pos_x) begin
					state_d = S_INS_VAL;
				end else begin
					idx_d   = idx_q - ADDR_W'(1);
					state_d = S_INS_RD;
				end
			end
			S_INS_VAL: begin
				we      = 1'b1;
				waddr   = ADDR_W'(pos_x - CMP_W'(1));
				count_d = count_q + CNT_W'(1);
				state_d = S_RESP;
			end
			// move the word above idx down by one
			S_DEL_RD: begin
				if (idx_x >= cnt_x) begin
					state_d = S_RESP;
				end else begin
					re      = 1'b1;
					raddr   = idx_q + ADDR_W'(1);
					state_d = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				we      = 1'b1;
				wdata   = rdata_q;
				idx_d   = idx_q + ADDR_W'(1);
				state_d = S_DEL_RD;
			end
			// emit one stored word per pass
			S_DISP_RD: begin
				re      = 1'b1;
				state_d = S_DISP_LD;
			end
			S_DISP_LD: begin
				if (slot_free) begin
					rsp_load              = 1'b1;
					rsp_d.status          = ST_OK;
					rsp_d.element         = rdata_q;
					rsp_d.element_index   = idx_inc_x[POS_W-1:0];
					rsp_d.length          = cnt_x[POS_W-1:0];
					rsp_d.last            = disp_last;
					if (disp_last) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + ADDR_W'(1);
						state_d = S_DISP_RD;
					end
				end
			end
			// single result of a non-display request or of a display of an empty list
			S_RESP: begin
				if (slot_free) begin
					rsp_load     = 1'b1;
					rsp_d.status = status_q;
					rsp_d.length = cnt_x[POS_W-1:0];
					rsp_d.last   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		pos_q    <= pos_d;
		val_q    <= val_d;
		status_q <= status_d;
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	// list memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	// count never passes the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	// every accepted request leaves idle
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> (state_q != S_IDLE))
		else $error("request accepted without work");

	// shift pointer stays inside the list during insert
	a_ins_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_WR) |-> (idx_x <= cnt_x) && (idx_x >= pos_x))
		else $error("insert pointer out of range");

	// a non-final result is always a display element
	a_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp.last) |-> (rsp.status == ST_OK) && (rsp.element_index != '0))
		else $error("non-final result is not a display element");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the positional list store
`timescale 1ns / 1ps

module tb
	import pls_pkg::*;
();

	// request codes the block leaves undefined; they get an OK result and leave the list unchanged
	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;
	localparam int RANDOM_ITEMS = 420;
	localparam int HOLD_CYCLES  = 400;
	localparam int HOLD_AFTER   = 150;
	localparam int SETTLE       = 150;

	// one row of the directed table; chk marks a typed-in single result
	typedef struct packed {
		logic [2:0]  code;
		logic [6:0]  pos;
		logic [31:0] val;
		logic        chk;
		logic [1:0]  st;
		logic [6:0]  len;
	} step_t;

	localparam int N_DIRECTED = 23;
	localparam step_t DIRECTED [N_DIRECTED] = '{
		'{REQ_DISPLAY, 7'd0,   32'h0000_0000, 1'b1, ST_EMPTY,  7'd0},
		'{REQ_MODIFY,  7'd1,   32'h1234_5678, 1'b1, ST_EMPTY,  7'd0},
		'{REQ_DELETE,  7'd1,   32'h0000_0000, 1'b1, ST_EMPTY,  7'd0},
		'{REQ_INSERT,  7'd1,   32'hdead_beef, 1'b1, ST_BADPOS, 7'd0},
		'{REQ_APPEND,  7'd0,   32'h7fff_ffff, 1'b1, ST_OK,     7'd1},
		'{REQ_APPEND,  7'd0,   32'h8000_0000, 1'b1, ST_OK,     7'd2},
		'{REQ_APPEND,  7'd0,   32'hffff_ffff, 1'b1, ST_OK,     7'd3},
		'{REQ_APPEND,  7'd127, 32'h0000_0000, 1'b1, ST_OK,     7'd4},
		'{REQ_MODIFY,  7'd0,   32'h0000_0001, 1'b1, ST_BADPOS, 7'd4},
		'{REQ_MODIFY,  7'd5,   32'h0000_0002, 1'b1, ST_BADPOS, 7'd4},
		'{REQ_MODIFY,  7'd127, 32'hffff_ffff, 1'b1, ST_BADPOS, 7'd4},
		'{REQ_MODIFY,  7'd4,   32'h5555_5555, 1'b1, ST_OK,     7'd4},
		'{REQ_INSERT,  7'd1,   32'haaaa_aaaa, 1'b0, ST_OK,     7'd0},
		'{REQ_INSERT,  7'd5,   32'h0f0f_0f0f, 1'b0, ST_OK,     7'd0},
		'{REQ_INSERT,  7'd7,   32'h0000_0003, 1'b1, ST_BADPOS, 7'd6},
		'{REQ_DISPLAY, 7'd64,  32'h0000_0000, 1'b0, ST_OK,     7'd0},
		'{REQ_DELETE,  7'd6,   32'h0000_0000, 1'b0, ST_OK,     7'd0},
		'{REQ_DELETE,  7'd1,   32'h0000_0000, 1'b0, ST_OK,     7'd0},
		'{REQ_DELETE,  7'd0,   32'h0000_0000, 1'b1, ST_BADPOS, 7'd4},
		'{REQ_SPARE_A, 7'd2,   32'h0000_0004, 1'b1, ST_OK,     7'd4},
		'{REQ_SPARE_B, 7'd3,   32'h0000_0005, 1'b1, ST_OK,     7'd4},
		'{REQ_CLEAR,   7'd0,   32'h0000_0000, 1'b1, ST_OK,     7'd0},
		'{REQ_DISPLAY, 7'd0,   32'h0000_0000, 1'b1, ST_EMPTY,  7'd0}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	positional_list_store DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// shadow copy of the list and the results still owed by the block
	logic signed [31:0] shadow_mem [DEPTH];
	int unsigned        shadow_len;
	rsp_t               pending_rsp [$];

	int errors = 0;
	int reqs_sent;
	int rsp_seen = 0;
	int full_hits;
	int badpos_hits;
	int tx_idle;
	int rx_idle;
	int hold_left = 0;
	bit hold_done = 1'b0;

	initial begin
		clk = 1'b0;
	end
	always #1 clk = ~clk;

	initial begin
		#1_000_000;
		$display("tb: errors");
		$finish;
	end

	// one result of the shadow list, pushed to the owed queue
	function automatic void owe_result(input status_t st, input logic signed [31:0] elem,
			input int unsigned idx, input bit fin);
		rsp_t o;
		o.status        = st;
		o.element       = elem;
		o.element_index = idx[6:0];
		o.length        = shadow_len[6:0];
		o.last          = fin;
		pending_rsp.push_back(o);
		if (st == ST_FULL)
			full_hits++;
		if (st == ST_BADPOS)
			badpos_hits++;
	endfunction

	// apply one request to the shadow list and queue what it owes
	function automatic void list_apply(input req_t r);
		int unsigned p;
		int unsigned n;
		int i;
		status_t st;
		p = r.position;
		st = ST_OK;
		case (r.req_type)
			REQ_CLEAR: begin
				shadow_len = 0;
			end
			REQ_APPEND: begin
				if (shadow_len >= DEPTH) begin
					st = ST_FULL;
				end else begin
					shadow_mem[shadow_len] = r.value;
					shadow_len++;
				end
			end
			REQ_MODIFY: begin
				if (shadow_len == 0)
					st = ST_EMPTY;
				else if (p < 1 || p > shadow_len)
					st = ST_BADPOS;
				else
					shadow_mem[p-1] = r.value;
			end
			REQ_DISPLAY: begin
				if (shadow_len == 0) begin
					owe_result(ST_EMPTY, 32'sd0, 0, 1'b1);
					return;
				end
				n = shadow_len;
				if (n > MAX_RESULTS)
					n = MAX_RESULTS;
				for (i = 0; i < n; i++)
					owe_result(ST_OK, shadow_mem[i], i + 1, (i + 1) == n);
				return;
			end
			REQ_INSERT: begin
				if (p < 1 || p > shadow_len) begin
					st = ST_BADPOS;
				end else if (shadow_len >= DEPTH) begin
					st = ST_FULL;
				end else begin
					for (i = shadow_len; i >= int'(p); i--)
						shadow_mem[i] = shadow_mem[i-1];
					shadow_mem[p-1] = r.value;
					shadow_len++;
				end
			end
			REQ_DELETE: begin
				if (shadow_len == 0) begin
					st = ST_EMPTY;
				end else if (p < 1 || p > shadow_len) begin
					st = ST_BADPOS;
				end else begin
					shadow_len--;
					for (i = p - 1; i < shadow_len; i++)
						shadow_mem[i] = shadow_mem[i+1];
				end
			end
			default: begin
			end
		endcase
		owe_result(st, 32'sd0, 0, 1'b1);
	endfunction

	// random request, biased to grow or to shrink the list
	function automatic req_t pick_request(input bit grow);
		req_t r;
		int unsigned w;
		int unsigned s;
		r.value = $urandom;
		s = $urandom_range(15);
		if (s == 0)
			r.value = 32'h7fff_ffff;
		else if (s == 1)
			r.value = 32'h8000_0000;
		else if (s == 2)
			r.value = 32'hffff_ffff;
		w = $urandom_range(99);
		if (grow) begin
			if (w < 45)      r.req_type = REQ_APPEND;
			else if (w < 70) r.req_type = REQ_INSERT;
			else if (w < 80) r.req_type = REQ_MODIFY;
			else if (w < 88) r.req_type = REQ_DELETE;
			else if (w < 95) r.req_type = REQ_DISPLAY;
			else if (w < 96) r.req_type = REQ_CLEAR;
			else if (w < 98) r.req_type = REQ_SPARE_A;
			else             r.req_type = REQ_SPARE_B;
		end else begin
			if (w < 12)      r.req_type = REQ_APPEND;
			else if (w < 22) r.req_type = REQ_INSERT;
			else if (w < 37) r.req_type = REQ_MODIFY;
			else if (w < 80) r.req_type = REQ_DELETE;
			else if (w < 92) r.req_type = REQ_DISPLAY;
			else if (w < 96) r.req_type = REQ_CLEAR;
			else if (w < 98) r.req_type = REQ_SPARE_A;
			else             r.req_type = REQ_SPARE_B;
		end
		// mostly legal positions, some at the edges, some noise
		s = $urandom_range(19);
		if (shadow_len > 0 && s < 15)
			r.position = 7'($urandom_range(shadow_len, 1));
		else if (s < 17)
			r.position = 7'd0;
		else if (s < 19)
			r.position = shadow_len[6:0] + 7'd1;
		else
			r.position = 7'($urandom_range(127, 0));
		return r;
	endfunction

	// offer one request, with random gaps, and book it once accepted
	task automatic send_request(input req_t r, input bit typed, input status_t st,
			input logic [6:0] len);
		rsp_t o;
		while ($urandom_range(99) < tx_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do
			@(negedge clk);
		while (!req_ready);
		@(posedge clk);
		reqs_sent++;
		list_apply(r);
		// typed-in rows replace the shadow's single result
		if (typed) begin
			void'(pending_rsp.pop_back());
			o.status        = st;
			o.element       = 32'sd0;
			o.element_index = 7'd0;
			o.length        = len;
			o.last          = 1'b1;
			pending_rsp.push_back(o);
		end
	endtask

	// receiver: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
			rsp_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// result checker, sampled mid-cycle while everything is stable
	always @(negedge clk) begin
		rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_seen++;
			if (pending_rsp.size() == 0) begin
				$error("unexpected result: status %0d element %0d", rsp.status, rsp.element);
				errors++;
			end else begin
				e = pending_rsp.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d, got %0d", e.status, rsp.status);
					errors++;
				end
				if (rsp.element !== e.element) begin
					$error("element: expected %0d, got %0d", e.element, rsp.element);
					errors++;
				end
				if (rsp.element_index !== e.element_index) begin
					$error("element_index: expected %0d, got %0d",
						e.element_index, rsp.element_index);
					errors++;
				end
				if (rsp.length !== e.length) begin
					$error("length: expected %0d, got %0d", e.length, rsp.length);
					errors++;
				end
				if (rsp.last !== e.last) begin
					$error("last: expected %0d, got %0d", e.last, rsp.last);
					errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		req_t r;
		int k;
		int drain;
		reqs_sent   = 0;
		full_hits   = 0;
		badpos_hits = 0;
		shadow_len  = 0;
		tx_idle     = 18;
		rx_idle     = 65;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		req         = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (k = 0; k < N_DIRECTED; k++) begin
			r.req_type = DIRECTED[k].code;
			r.position = DIRECTED[k].pos;
			r.value    = DIRECTED[k].val;
			send_request(r, DIRECTED[k].chk, status_t'(DIRECTED[k].st), DIRECTED[k].len);
		end

		// random part in three idling phases, grow and shrink epochs
		k = 0;
		while (k < RANDOM_ITEMS) begin
			if (k < RANDOM_ITEMS / 3) begin
				tx_idle = 18;
				rx_idle = 65;
			end else if (k < 2 * RANDOM_ITEMS / 3) begin
				tx_idle = 65;
				rx_idle = 18;
			end else begin
				tx_idle = 0;
				rx_idle = 0;
			end
			r = pick_request(((k / 50) % 2) == 0);
			send_request(r, 1'b0, ST_OK, 7'd0);
			if (r.req_type != REQ_SPARE_A && r.req_type != REQ_SPARE_B)
				k++;
		end

		// drain owed results, then let any late extras show up
		req_valid <= 1'b0;
		drain = 0;
		while (pending_rsp.size() != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		repeat (SETTLE) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$error("%0d results never arrived", pending_rsp.size());
			errors++;
		end

		$display("summary: %0d requests, %0d results checked", reqs_sent, rsp_seen);
		$display("summary: %0d full and %0d bad-position statuses seen, one long output stall",
			full_hits, badpos_hits);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/pls_pkg.sv
hdl/positional_list_store.sv
tb/tb.sv
